// File: design/bps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, codes and duration tables of the buzzer pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TONE    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_TONE    = 2'd1,
    MODE_PATTERN = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_SOUND = 2'd0,
    PH_QUIET = 2'd1,
    PH_GAP   = 2'd2
  } phase_t;

  localparam logic CFG_SOUND_ON = 1'b0;
  localparam logic CFG_VOLUME   = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  pattern_select;
    logic [15:0] tone_length_ms;
    logic [15:0] tone_frequency;
  } in_item_t;

  typedef struct packed {
    logic buzzer_drive;
    logic busy_res;
    logic finished;
  } out_item_t;

  // Classified command handed from the front end to the player
  typedef struct packed {
    cmd_t        kind;
    logic [2:0]  pat;
    logic [15:0] len;
    logic        audible;
  } op_t;

  localparam logic [8:0] PAT_TAB [8][17] = '{
    '{9'd150, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
      9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd30, 9'd30, 9'd30, 9'd30, 9'd30, 9'd30, 9'd30, 9'd30, 9'd30,
      9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd60, 9'd60, 9'd60, 9'd60, 9'd60, 9'd180, 9'd180, 9'd60, 9'd180,
      9'd60, 9'd180, 9'd180, 9'd60, 9'd60, 9'd60, 9'd60, 9'd60},
    '{9'd200, 9'd100, 9'd300, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
      9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd300, 9'd200, 9'd300, 9'd200, 9'd300, 9'd0, 9'd0, 9'd0, 9'd0,
      9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd40, 9'd60, 9'd40, 9'd60, 9'd40, 9'd60, 9'd200, 9'd100, 9'd50,
      9'd50, 9'd50, 9'd50, 9'd300, 9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
      9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
      9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0}
  };

  localparam logic [4:0] PAT_LEN [8] = '{
    5'd1, 5'd9, 5'd17, 5'd3, 5'd5, 5'd13, 5'd0, 5'd0
  };

  function automatic logic [4:0] pat_len(input logic [2:0] pat);
    return PAT_LEN[pat];
  endfunction

  function automatic logic [8:0] pat_dur(input logic [2:0] pat, input logic [4:0] pos);
    logic [8:0] v;
    v = '0;
    if (pos < 5'd17) begin
      v = PAT_TAB[pat][pos];
    end
    return v;
  endfunction

  function automatic logic [6:0] vol_max(input logic [1:0] level);
    logic [6:0] m;
    case (level)
      2'd0:    m = 7'd20;
      2'd1:    m = 7'd50;
      default: m = 7'd100;
    endcase
    return m;
  endfunction

endpackage

// File: design/buzzer_pattern_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer
// Millisecond-tick driven tone and pattern player for an active buzzer.
// ----------------------------------------------------------------------------
// Every item (tick, pattern start, tone start) yields exactly one result item
// showing buzzer level, busy and the end-of-playback pulse. One item is taken
// per clock while the command queue is not full; its result passes through the
// command queue and then the result queue before it can be popped, and the
// playback engine retires one queued item per cycle while the result queue has
// room. Both queues hold two items, so up to four items are taken while
// results wait to be popped before full rises. There is no start-up clearing
// pass. Write configuration only while no result is outstanding.
module buzzer_pattern_sequencer import bps_pkg::*; #(
  parameter int PATTERN_COUNT       = 6,
  parameter int VOLUME_LEVELS       = 3,
  parameter int MAX_PATTERN_ENTRIES = 17
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [1:0] cfg_wdata
);

  logic       sound_on_r;
  logic [1:0] volume_r;

  op_t        op;
  logic       op_empty;
  logic       op_pop;
  out_item_t  res;
  logic       res_push;
  logic       res_full;
  logic [$bits(out_item_t)-1:0] out_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sound_on_r <= 1'b1;
      volume_r   <= 2'd2;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SOUND_ON) begin
        sound_on_r <= cfg_wdata[0];
      end else if ({1'b0, cfg_wdata} < 3'(VOLUME_LEVELS)) begin
        volume_r <= cfg_wdata;
      end
    end
  end

  bps_front #(
    .PATTERN_COUNT (PATTERN_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .sound_on (sound_on_r),
    .op_pop   (op_pop),
    .op       (op),
    .op_empty (op_empty)
  );

  bps_back #(
    .MAX_PATTERN_ENTRIES (MAX_PATTERN_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .op_empty (op_empty),
    .op_pop   (op_pop),
    .volume   (volume_r),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  bps_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_raw),
    .empty (out_empty)
  );

  assign out_item = out_item_t'(out_raw);

  // the engine only retires a command when its result has a slot
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_pop_matches_push: assert property (@(posedge clk) disable iff (!rst_n)
    op_pop |-> (res_push && !op_empty))
    else $error("command retired without a result");

  a_finish_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.finished) |-> (!out_item.busy_res && !out_item.buzzer_drive))
    else $error("finished reported while still playing");

  a_drive_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.buzzer_drive) |-> out_item.busy_res)
    else $error("buzzer driven while idle");

endmodule

// File: design/bps_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module bps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: design/bps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_front
// Accepts items, screens start commands and queues them for the player.
// ----------------------------------------------------------------------------
module bps_front import bps_pkg::*; #(
  parameter int PATTERN_COUNT = 6
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_item,
  output logic     in_full,
  input  logic     sound_on,
  input  logic     op_pop,
  output op_t      op,
  output logic     op_empty
);

  op_t                   op_in;
  logic [$bits(op_t)-1:0] op_raw;

  // Pattern starts that can never play, and empty tones, become no-ops here
  always_comb begin
    op_in.kind    = CMD_NOP;
    op_in.pat     = in_item.pattern_select;
    op_in.len     = in_item.tone_length_ms;
    op_in.audible = sound_on & (in_item.tone_frequency != '0);
    case (cmd_t'(in_item.command))
      CMD_TICK: op_in.kind = CMD_TICK;
      CMD_PATTERN: begin
        if (sound_on && ({1'b0, in_item.pattern_select} < 4'(PATTERN_COUNT)) &&
            (pat_len(in_item.pattern_select) != '0)) begin
          op_in.kind = CMD_PATTERN;
        end
      end
      CMD_TONE: begin
        if (in_item.tone_length_ms != '0) begin
          op_in.kind = CMD_TONE;
        end
      end
      default: op_in.kind = CMD_NOP;
    endcase
  end

  bps_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (op_in),
    .full  (in_full),
    .pop   (op_pop),
    .rdata (op_raw),
    .empty (op_empty)
  );

  assign op = op_t'(op_raw);

endmodule

// File: design/bps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_back
// Playback engine: runs tone and pattern timing, one queued item per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module bps_back import bps_pkg::*; #(
  parameter int MAX_PATTERN_ENTRIES = 17
) (
  input  logic       clk,
  input  logic       rst_n,
  input  op_t        op,
  input  logic       op_empty,
  output logic       op_pop,
  input  logic [1:0] volume,
  input  logic       res_full,
  output logic       res_push,
  output out_item_t  res
);

  mode_t       mode_r, mode_nxt;
  phase_t      phase_r, phase_nxt;
  logic [2:0]  pat_r, pat_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [15:0] ms_r, ms_nxt;
  logic [15:0] quiet_r, quiet_nxt;
  logic        fin;

  logic        go;
  logic [4:0]  pos_inc;
  logic [4:0]  limit;
  logic [15:0] ms_dec;
  logic [15:0] load_d;
  logic [15:0] cap;
  logic [15:0] on_a;
  logic [15:0] on_q;

  assign go       = ~op_empty & ~res_full;
  assign op_pop   = go;
  assign res_push = go;

  assign pos_inc = pos_r + 5'd1;
  assign limit   = (pat_len(pat_r) > 5'(MAX_PATTERN_ENTRIES)) ?
                   5'(MAX_PATTERN_ENTRIES) : pat_len(pat_r);
  assign ms_dec  = (ms_r != '0) ? ms_r - 16'd1 : '0;

  // One shared cap unit splits an on-duration into sounding and quiet parts
  always_comb begin
    case (op.kind)
      CMD_TONE:    load_d = op.len;
      CMD_PATTERN: load_d = 16'(pat_dur(op.pat, 5'd0));
      default:     load_d = 16'(pat_dur(pat_r, pos_inc));
    endcase
  end

  assign cap  = 16'(vol_max(volume));
  assign on_a = (load_d < cap) ? load_d : cap;
  assign on_q = load_d - on_a;

  // Next state
  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    pat_nxt   = pat_r;
    pos_nxt   = pos_r;
    ms_nxt    = ms_r;
    quiet_nxt = quiet_r;
    fin       = 1'b0;
    if (go) begin
      case (op.kind)
        CMD_TICK: begin
          if (mode_r != MODE_IDLE) begin
            ms_nxt = ms_dec;
            if (ms_dec == '0) begin
              if (phase_r == PH_SOUND && quiet_r != '0) begin
                phase_nxt = PH_QUIET;
                ms_nxt    = quiet_r;
                quiet_nxt = '0;
              end else if (mode_r == MODE_PATTERN && pos_inc < limit) begin
                pos_nxt = pos_inc;
                if (pos_inc[0]) begin
                  phase_nxt = PH_GAP;
                  ms_nxt    = load_d;
                  quiet_nxt = '0;
                end else begin
                  phase_nxt = PH_SOUND;
                  ms_nxt    = on_a;
                  quiet_nxt = on_q;
                end
              end else begin
                if (mode_r == MODE_PATTERN) begin
                  pos_nxt = pos_inc;
                end
                mode_nxt  = MODE_IDLE;
                phase_nxt = PH_SOUND;
                quiet_nxt = '0;
                fin       = 1'b1;
              end
            end
          end
        end
        CMD_PATTERN: begin
          if (mode_r == MODE_IDLE) begin
            mode_nxt  = MODE_PATTERN;
            pat_nxt   = op.pat;
            pos_nxt   = '0;
            phase_nxt = PH_SOUND;
            ms_nxt    = on_a;
            quiet_nxt = on_q;
          end
        end
        CMD_TONE: begin
          if (mode_r == MODE_IDLE) begin
            mode_nxt = MODE_TONE;
            pos_nxt  = '0;
            if (op.audible) begin
              phase_nxt = PH_SOUND;
              ms_nxt    = on_a;
              quiet_nxt = on_q;
            end else begin
              // silent tone: skip straight to the quiet part
              phase_nxt = PH_QUIET;
              ms_nxt    = op.len;
              quiet_nxt = '0;
            end
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    res.buzzer_drive = (mode_nxt != MODE_IDLE) && (phase_nxt == PH_SOUND);
    res.busy_res     = (mode_nxt != MODE_IDLE);
    res.finished     = fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      phase_r <= PH_SOUND;
      pat_r   <= '0;
      pos_r   <= '0;
      ms_r    <= '0;
      quiet_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      pat_r   <= pat_nxt;
      pos_r   <= pos_nxt;
      ms_r    <= ms_nxt;
      quiet_r <= quiet_nxt;
    end
  end

endmodule

// File: dv/buzzer_pattern_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_pattern_checker
// Watches the item and result channels of the buzzer sequencer, keeps its own
// model of the player and compares every popped result against it.
// ----------------------------------------------------------------------------
module buzzer_pattern_checker import bps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  in_item_t   in_item,
  input  logic       out_empty,
  input  logic       out_pop,
  input  out_item_t  out_item,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_wdata,
  output int         errors,
  output int         pending,
  output logic       playing
);

  localparam int NUM_PATTERNS = 6;
  localparam int NUM_VOLUMES  = 3;
  localparam int ENTRY_CAP    = 17;

  // player copy
  mode_t       player_mode;
  phase_t      player_phase;
  logic [2:0]  cur_pat;
  logic [4:0]  cur_pos;
  logic [15:0] ms_left;
  logic [15:0] quiet_left;
  logic        sound_en;
  logic [1:0]  vol_sel;

  out_item_t   buzzer_states_due[$];
  int          fails = 0;

  assign errors = fails;

  function automatic int entries_of(input logic [2:0] pat);
    int n;
    case (pat)
      3'd0:    n = 1;
      3'd1:    n = 9;
      3'd2:    n = 17;
      3'd3:    n = 3;
      3'd4:    n = 5;
      3'd5:    n = 13;
      default: n = 0;
    endcase
    if (n > ENTRY_CAP) n = ENTRY_CAP;
    return n;
  endfunction

  function automatic logic [15:0] entry_ms(input logic [2:0] pat, input logic [4:0] pos);
    logic [15:0] ms;
    ms = 16'd0;
    case (pat)
      3'd0: ms = 16'd150;
      3'd1: ms = 16'd30;
      3'd2: begin
        case (pos)
          5'd5, 5'd6, 5'd8, 5'd10, 5'd11: ms = 16'd180;
          default:                        ms = 16'd60;
        endcase
      end
      3'd3: begin
        case (pos)
          5'd0:    ms = 16'd200;
          5'd1:    ms = 16'd100;
          default: ms = 16'd300;
        endcase
      end
      3'd4: ms = pos[0] ? 16'd200 : 16'd300;
      3'd5: begin
        case (pos)
          5'd0, 5'd2, 5'd4:         ms = 16'd40;
          5'd1, 5'd3, 5'd5:         ms = 16'd60;
          5'd6:                     ms = 16'd200;
          5'd7:                     ms = 16'd100;
          5'd8, 5'd9, 5'd10, 5'd11: ms = 16'd50;
          default:                  ms = 16'd300;
        endcase
      end
      default: ms = 16'd0;
    endcase
    return ms;
  endfunction

  function automatic logic [15:0] beep_cap();
    logic [15:0] m;
    case (vol_sel)
      2'd0:    m = 16'd20;
      2'd1:    m = 16'd50;
      default: m = 16'd100;
    endcase
    return m;
  endfunction

  // Split an on-duration into the sounding part and the silent rest
  function automatic void load_beep(input logic [15:0] dur, input logic audible);
    logic [15:0] loud;
    loud = 16'd0;
    if (audible) loud = (dur < beep_cap()) ? dur : beep_cap();
    player_phase = PH_SOUND;
    ms_left      = loud;
    quiet_left   = dur - loud;
  endfunction

  // Step past exhausted phases; returns 1 when the playback is over
  function automatic logic roll_phase();
    int   guard;
    logic stop;
    stop = 1'b0;
    for (guard = 0; guard < 80 && ms_left == 16'd0 && !stop; guard = guard + 1) begin
      if (player_phase == PH_SOUND && quiet_left != 16'd0) begin
        player_phase = PH_QUIET;
        ms_left      = quiet_left;
        quiet_left   = 16'd0;
      end else if (player_mode != MODE_PATTERN) begin
        stop = 1'b1;
      end else begin
        cur_pos = cur_pos + 5'd1;
        if (cur_pos >= entries_of(cur_pat)) begin
          stop = 1'b1;
        end else if (cur_pos[0]) begin
          player_phase = PH_GAP;
          ms_left      = entry_ms(cur_pat, cur_pos);
          quiet_left   = 16'd0;
        end else begin
          load_beep(entry_ms(cur_pat, cur_pos), 1'b1);
        end
      end
    end
    if (ms_left == 16'd0) begin
      player_mode  = MODE_IDLE;
      player_phase = PH_SOUND;
      quiet_left   = 16'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t next_buzzer_state(input in_item_t it);
    logic      ended;
    out_item_t r;
    ended = 1'b0;
    case (it.command)
      CMD_TICK: begin
        if (player_mode != MODE_IDLE) begin
          if (ms_left != 16'd0) ms_left = ms_left - 16'd1;
          if (ms_left == 16'd0) ended = roll_phase();
        end
      end
      CMD_PATTERN: begin
        if (player_mode == MODE_IDLE && sound_en && it.pattern_select < NUM_PATTERNS &&
            entries_of(it.pattern_select) != 0) begin
          player_mode = MODE_PATTERN;
          cur_pat     = it.pattern_select;
          cur_pos     = 5'd0;
          load_beep(entry_ms(it.pattern_select, 5'd0), 1'b1);
          if (ms_left == 16'd0) void'(roll_phase());
        end
      end
      CMD_TONE: begin
        if (player_mode == MODE_IDLE && it.tone_length_ms != 16'd0) begin
          player_mode = MODE_TONE;
          cur_pos     = 5'd0;
          load_beep(it.tone_length_ms, sound_en && it.tone_frequency != 16'd0);
          if (ms_left == 16'd0) void'(roll_phase());
        end
      end
      default: ;
    endcase
    r.buzzer_drive = (player_mode != MODE_IDLE) && (player_phase == PH_SOUND);
    r.busy_res     = (player_mode != MODE_IDLE);
    r.finished     = ended;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      player_mode  = MODE_IDLE;
      player_phase = PH_SOUND;
      cur_pat      = 3'd0;
      cur_pos      = 5'd0;
      ms_left      = 16'd0;
      quiet_left   = 16'd0;
      sound_en     = 1'b1;
      vol_sel      = 2'd2;
      buzzer_states_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SOUND_ON) sound_en = cfg_wdata[0];
        else if (cfg_wdata < NUM_VOLUMES) vol_sel = cfg_wdata;
      end
      if (out_pop && !out_empty) begin
        if (buzzer_states_due.size() == 0) begin
          $error("result item with nothing expected: %p", out_item);
          fails++;
        end else begin
          want = buzzer_states_due.pop_front();
          if (out_item.buzzer_drive !== want.buzzer_drive) begin
            $error("buzzer_drive: expected %0b, got %0b", want.buzzer_drive,
                   out_item.buzzer_drive);
            fails++;
          end
          if (out_item.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, out_item.busy_res);
            fails++;
          end
          if (out_item.finished !== want.finished) begin
            $error("finished: expected %0b, got %0b", want.finished, out_item.finished);
            fails++;
          end
        end
      end
      if (in_push && !in_full) buzzer_states_due.push_back(next_buzzer_state(in_item));
    end
    pending <= buzzer_states_due.size();
    playing <= (player_mode != MODE_IDLE);
  end

endmodule

// File: dv/buzzer_pattern_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer_tb
// Drives ticks, tone and pattern starts into the sequencer under several
// sound/volume settings with random idling on both queues; a checker module
// predicts every result item and counts mismatches.
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer_tb;
  import bps_pkg::*;

  localparam int STALL_LIMIT = 1000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_push   = 1'b0;
  in_item_t   in_item   = '0;
  logic       out_pop   = 1'b0;
  logic       cfg_we    = 1'b0;
  logic       cfg_index = CFG_SOUND_ON;
  logic [1:0] cfg_wdata = 2'd0;
  logic       in_full;
  logic       out_empty;
  out_item_t  out_item;

  int   fail_count;
  int   pending;
  logic playing;

  logic calm        = 1'b0;
  int   gap_pct     = 20;
  int   stall_pct   = 10;
  int   sent        = 0;
  int   next_pat    = 0;
  int   quiet_cycles = 0;

  always #10 clk = ~clk;

  buzzer_pattern_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  buzzer_pattern_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (fail_count),
    .pending   (pending),
    .playing   (playing)
  );

  function automatic in_item_t mk_item(input cmd_t c, input logic [2:0] sel,
                                       input logic [15:0] len, input logic [15:0] freq);
    in_item_t it;
    it.command        = c;
    it.pattern_select = sel;
    it.tone_length_ms = len;
    it.tone_frequency = freq;
    return it;
  endfunction

  // tick fields are don't-care, so they carry random bits
  function automatic in_item_t tick_item();
    return mk_item(CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  function automatic logic [15:0] rand_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) return 16'd0;
    if (p < 55) return 16'($urandom_range(1, 30));
    if (p < 82) return 16'($urandom_range(31, 110));
    return 16'($urandom_range(111, 300));
  endfunction

  function automatic logic [15:0] rand_freq();
    if ($urandom_range(0, 3) == 0) return 16'd0;
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic in_item_t noise_item();
    case ($urandom_range(0, 3))
      0:       return mk_item(CMD_NOP, 3'($urandom), 16'($urandom), 16'($urandom));
      1:       return mk_item(CMD_PATTERN, 3'($urandom), 16'($urandom), 16'($urandom));
      2:       return mk_item(CMD_TONE, 3'($urandom), 16'($urandom_range(0, 300)),
                              rand_freq());
      default: return tick_item();
    endcase
  endfunction

  task automatic push_item(input in_item_t it);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    sent++;
  endtask

  // Tick the running playback along, with stray commands mixed in, until it
  // is over or the phase has used up its items
  task automatic play_out(input int stop_at);
    do begin
      if ($urandom_range(0, 9) == 0) push_item(noise_item());
      else push_item(tick_item());
    end while (playing && sent < stop_at);
  endtask

  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_episode(input int stop_at);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      push_item(mk_item(CMD_TONE, 3'($urandom), rand_len(), rand_freq()));
      play_out(stop_at);
    end else if (pick < 75) begin
      push_item(mk_item(CMD_PATTERN, 3'($urandom), 16'($urandom), 16'($urandom)));
      play_out(stop_at);
    end else begin
      repeat ($urandom_range(1, 5)) push_item(noise_item());
    end
  endtask

  // One configuration setting: optionally start the next table pattern, then
  // keep ticking and starting episodes until the item budget is spent. A
  // playback still running at the end carries over into the next setting.
  task automatic run_phase(input int budget, input logic with_patterns);
    int stop_at;
    stop_at   = sent + budget;
    gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
    stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 25);
    if (with_patterns && !playing) begin
      push_item(mk_item(CMD_PATTERN, 3'(next_pat), 16'($urandom), 16'($urandom)));
      next_pat = (next_pat + 1) % 6;
    end
    while (sent < stop_at) begin
      if (playing) play_out(stop_at);
      else random_episode(stop_at);
    end
    settle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    wait (rst_n === 1'b1);
    forever begin
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);

    // directed: idle tick, no-op, zero-length tone, starts while busy,
    // unknown patterns, silent tone
    push_item(tick_item());
    push_item(mk_item(CMD_NOP, 3'd7, 16'hFFFF, 16'hFFFF));
    push_item(mk_item(CMD_TONE, 3'd0, 16'd0, 16'hFFFF));
    push_item(mk_item(CMD_TONE, 3'd0, 16'd1, 16'd1));
    push_item(mk_item(CMD_TONE, 3'd7, 16'hFFFF, 16'hFFFF));
    push_item(mk_item(CMD_PATTERN, 3'd0, 16'd0, 16'd0));
    push_item(mk_item(CMD_NOP, 3'd0, 16'd0, 16'd0));
    push_item(tick_item());
    push_item(tick_item());
    push_item(mk_item(CMD_PATTERN, 3'd6, 16'd0, 16'd0));
    push_item(mk_item(CMD_PATTERN, 3'd7, 16'hFFFF, 16'hFFFF));
    push_item(mk_item(CMD_TONE, 3'd0, 16'd2, 16'd0));
    repeat (3) push_item(tick_item());
    push_item(mk_item(CMD_TONE, 3'd5, 16'd3, 16'h8000));
    repeat (4) push_item(tick_item());
    settle();

    write_reg(CFG_SOUND_ON, 2'd1);
    write_reg(CFG_VOLUME, 2'd0);
    run_phase(50, 1'b1);

    write_reg(CFG_VOLUME, 2'd1);
    run_phase(50, 1'b0);

    write_reg(CFG_SOUND_ON, 2'd0);
    write_reg(CFG_VOLUME, 2'd2);
    run_phase(50, 1'b0);

    // out-of-range volume is dropped, level stays at 2
    write_reg(CFG_SOUND_ON, 2'd1);
    write_reg(CFG_VOLUME, 2'd3);
    run_phase(50, 1'b1);

    write_reg(CFG_VOLUME, 2'd0);
    write_reg(CFG_VOLUME, 2'd3);
    run_phase(50, 1'b0);

    write_reg(CFG_SOUND_ON, 2'd0);
    write_reg(CFG_VOLUME, 2'd1);
    run_phase(50, 1'b0);

    calm = 1'b1;
    write_reg(CFG_SOUND_ON, 2'd1);
    write_reg(CFG_VOLUME, 2'd2);
    run_phase(50, 1'b1);

    // longest tone, left running
    push_item(mk_item(CMD_TONE, 3'd0, 16'hFFFF, 16'hFFFF));
    repeat (20) push_item(tick_item());
    push_item(mk_item(CMD_PATTERN, 3'd0, 16'd0, 16'd0));
    settle();
    repeat (10) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
